[rtl/dta_pkg.sv]
// Shared types and constants for the depth temporal average unit.
// No dependencies; imported by the top level, dta_checker and the testbench files.
package dta_pkg;

  localparam int unsigned HISTORY_DEPTH_DEF = 5;
  localparam int unsigned MAX_PIXELS_DEF    = 262144;

  localparam int unsigned DEPTH_W    = 16;
  localparam int unsigned PPF_W      = 19;
  localparam int unsigned THR_W      = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 19;

  localparam logic [PPF_W-1:0] PPF_RESET = PPF_W'(217088);
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(10);

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_PIXELS_PER_FRAME = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_CHANGE_THRESHOLD = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_DONE
  } dta_state_e;

endpackage

[rtl/dta_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module dta_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/dta_div.sv]
// Iterative restoring divider, one quotient bit per cycle.
// No dependencies; used by the top level to average the history row.
module dta_div #(
  parameter int unsigned DVD_W = 19,
  parameter int unsigned DVS_W = 3
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(DVD_W);

  logic             run_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DVD_W-1:0] quo_q, quo_d;
  logic [DVS_W-1:0] rem_q, rem_d, dvs_q;
  logic [DVS_W:0]   trial;
  logic             fits;

  always_comb begin
    trial = {rem_q, quo_q[DVD_W-1]};
    fits  = (trial >= {1'b0, dvs_q});
    rem_d = fits ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
    quo_d = {quo_q[DVD_W-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DVD_W - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (run_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

[rtl/depth_temporal_average_unit.sv]
// Top level of the depth temporal average unit: control, pointers, averaging.
// Depends on dta_pkg, dta_ram (history store) and dta_div (averaging divider).
//
// Usage:
//   Depth pixels enter in raster order on the input channel (in_valid_i,
//   in_stall_o, depth_sample_i). Each item yields exactly one result on the
//   output channel (out_valid_o, out_stall_i, filtered_depth_o, frame_end_o).
//   The history of every pixel position (HISTORY_DEPTH frames) is one row of
//   a single RAM; an item reads its row, merges the new sample into the
//   current frame slot, averages the nonzero entries and writes the row back.
//   Items are processed one at a time:
//     - position with any nonzero history: the item waits for the
//       bit-serial divider that forms the average;
//     - position with an all-zero history: the divider is skipped.
//   A result sits in the output register; a stalled receiver holds it, and
//   the next item is already taken and worked on, waiting only at write-out.
//   After reset the history RAM is cleared one row per cycle, all MAX_PIXELS
//   rows, with in_stall_o high; configuration writes are taken at any time,
//   but only while the block is idle by contract.
module depth_temporal_average_unit #(
  parameter int unsigned HISTORY_DEPTH = dta_pkg::HISTORY_DEPTH_DEF,
  parameter int unsigned MAX_PIXELS    = dta_pkg::MAX_PIXELS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dta_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [dta_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [dta_pkg::DEPTH_W-1:0]   depth_sample_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [dta_pkg::DEPTH_W-1:0]   filtered_depth_o,
  output logic                          frame_end_o
);

  import dta_pkg::*;

  localparam int unsigned ADDR_W = $clog2(MAX_PIXELS);
  localparam int unsigned SLOT_W = $clog2(HISTORY_DEPTH);
  localparam int unsigned NUM_W  = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned SUM_W  = DEPTH_W + $clog2(HISTORY_DEPTH);
  localparam int unsigned ROW_W  = DEPTH_W * HISTORY_DEPTH;
  localparam int unsigned CNT_W  = $clog2(MAX_PIXELS + 1);
  localparam int unsigned LEN_W  = ((CNT_W > PPF_W) ? CNT_W : PPF_W) + 1;

  typedef logic [HISTORY_DEPTH-1:0][DEPTH_W-1:0] row_t;

  dta_state_e state_q, state_d;

  // Configuration registers
  logic [PPF_W-1:0] ppf_q;
  logic [THR_W-1:0] thr_q;

  // Frame pointers
  logic [ADDR_W-1:0] pos_q;
  logic [SLOT_W-1:0] slot_q;
  logic [ADDR_W-1:0] clr_q;

  // Item in flight
  logic [DEPTH_W-1:0] raw_q;
  logic [ADDR_W-1:0]  addr_q;
  logic [SLOT_W-1:0]  wslot_q;
  logic               last_q;
  logic               has_q;
  row_t               row_q;

  // Output register
  logic               out_valid_q;
  logic [DEPTH_W-1:0] out_depth_q;
  logic               out_end_q;

  // Combinational
  logic              in_acc, out_free, load_out;
  logic [LEN_W-1:0]  len_eff, pos_next;
  logic              last;
  row_t              row_rd, merged;
  logic [SUM_W-1:0]  sum;
  logic [NUM_W-1:0]  num;
  logic [ROW_W-1:0]  ram_rdata, ram_wdata;
  logic [ADDR_W-1:0] ram_waddr;
  logic              ram_we, ram_re;
  logic              div_start, div_done;
  logic [SUM_W-1:0]  div_quo;
  logic [DEPTH_W-1:0] avg, diff, result;
  logic              big_change;

  // ---------------------------------------------------------------------------
  // Configuration writes; indexes beyond the list are dropped
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppf_q <= PPF_RESET;
      thr_q <= THR_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PIXELS_PER_FRAME: ppf_q <= cfg_data_i[PPF_W-1:0];
        CFG_CHANGE_THRESHOLD: thr_q <= cfg_data_i[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective frame length: zero acts as one, clamp at MAX_PIXELS
  always_comb begin
    if (ppf_q == '0) begin
      len_eff = LEN_W'(1);
    end else if (LEN_W'(ppf_q) > LEN_W'(MAX_PIXELS)) begin
      len_eff = LEN_W'(MAX_PIXELS);
    end else begin
      len_eff = LEN_W'(ppf_q);
    end
    pos_next = LEN_W'(pos_q) + LEN_W'(1);
    last     = (pos_next >= len_eff);
  end

  // ---------------------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------------------
  assign out_free = !out_valid_q || !out_stall_i;
  assign in_acc   = in_valid_i && !in_stall_o;

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    ram_re     = 1'b0;
    ram_we     = 1'b0;
    div_start  = 1'b0;
    load_out   = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we = 1'b1;
        if (clr_q == ADDR_W'(MAX_PIXELS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        ram_re     = 1'b1;
        if (in_valid_i) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        if (num != '0) begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          ram_we   = 1'b1;
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      pos_q   <= '0;
      slot_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + ADDR_W'(1);
      end
      // Advance the frame pointers as soon as an item is taken
      if (in_acc) begin
        if (last) begin
          pos_q  <= '0;
          slot_q <= (slot_q == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : slot_q + SLOT_W'(1);
        end else begin
          pos_q <= pos_next[ADDR_W-1:0];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // History store: one row of HISTORY_DEPTH samples per pixel position
  // ---------------------------------------------------------------------------
  always_comb begin
    if (state_q == ST_CLEAR) begin
      ram_waddr = clr_q;
      ram_wdata = '0;
    end else begin
      ram_waddr = addr_q;
      ram_wdata = big_change ? '0 : ROW_W'(row_q);
    end
  end

  dta_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_PIXELS)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (pos_q),
    .rdata_o (ram_rdata)
  );

  // Merge the new sample into its slot, then sum the nonzero entries
  always_comb begin
    row_rd = row_t'(ram_rdata);
    merged = row_rd;
    merged[wslot_q] = raw_q;
    sum = '0;
    num = '0;
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      if (merged[i] != '0) begin
        sum = sum + SUM_W'(merged[i]);
        num = num + NUM_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      raw_q   <= depth_sample_i;
      addr_q  <= pos_q;
      wslot_q <= slot_q;
      last_q  <= last;
    end
    if (state_q == ST_READ) begin
      row_q <= merged;
      has_q <= (num != '0);
    end
  end

  dta_div #(
    .DVD_W (SUM_W),
    .DVS_W (NUM_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum),
    .divisor_i  (num),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Large change: pass the raw sample and wipe the position's history
  always_comb begin
    avg        = has_q ? div_quo[DEPTH_W-1:0] : '0;
    diff       = (raw_q > avg) ? raw_q - avg : avg - raw_q;
    big_change = has_q && (diff > thr_q);
    result     = big_change ? raw_q : avg;
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_depth_q <= result;
      out_end_q   <= last_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign filtered_depth_o = out_depth_q;
  assign frame_end_o      = out_end_q;

endmodule

[rtl/dta_checker.sv]
// Port-level checks for the depth temporal average unit, bound to its top level.
// Depends on dta_pkg for field widths.
module dta_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [dta_pkg::DEPTH_W-1:0] filtered_depth_o,
  input logic                        frame_end_o
);

  import dta_pkg::*;

  // Hold the input off when reset releases and the history clear begins
  a_clear_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> in_stall_o)
    else $error("input open right after reset");

  // Take one item at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("second item taken while one is in flight");

  // A new result only appears while an item is in flight
  a_result_from_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without an item in flight");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(filtered_depth_o) && $stable(frame_end_o)))
    else $error("stalled result changed");

endmodule

bind depth_temporal_average_unit dta_checker u_dta_checker (.*);

[tb/sv/depth_average_checker.sv]
// Checker for the depth temporal average unit: watches the register port and both
// item channels, predicts every filtered pixel and compares it field by field.
// Depends on dta_pkg for widths, reset values and register indexes.
module depth_average_checker
  import dta_pkg::*;
#(
  parameter int unsigned HISTORY_DEPTH = HISTORY_DEPTH_DEF,
  parameter int unsigned MAX_PIXELS    = MAX_PIXELS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic [DEPTH_W-1:0]    depth_sample_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [DEPTH_W-1:0]    filtered_depth_i,
  input  logic                  frame_end_i,
  output int unsigned           mismatch_count_o,
  output int unsigned           pending_o
);

  typedef logic [HISTORY_DEPTH*DEPTH_W-1:0] history_row_t;

  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    logic               frame_end;
  } pixel_result_t;

  // Sparse per-position history; a missing row reads as all zero.
  history_row_t     history_rows [int unsigned];
  pixel_result_t    expected_pixels [$];
  logic [PPF_W-1:0] pixels_per_frame;
  logic [THR_W-1:0] change_threshold;
  int unsigned      frame_slot;
  int unsigned      pixel_pos;

  function automatic pixel_result_t smooth_pixel(input logic [DEPTH_W-1:0] raw);
    history_row_t  row;
    int unsigned   sum;
    int unsigned   cnt;
    int unsigned   avg;
    int unsigned   diff;
    int unsigned   len;
    int unsigned   pos;
    pixel_result_t res;
    pos = pixel_pos;
    row = history_rows.exists(pos) ? history_rows[pos] : '0;
    row[frame_slot*DEPTH_W +: DEPTH_W] = raw;
    sum = 0;
    cnt = 0;
    res.depth = '0;
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      if (row[i*DEPTH_W +: DEPTH_W] != '0) begin
        sum += row[i*DEPTH_W +: DEPTH_W];
        cnt++;
      end
    end
    if (cnt != 0) begin
      avg = sum / cnt;
      diff = (raw > avg) ? raw - avg : avg - raw;
      res.depth = DEPTH_W'(avg);
      // large change: pass the raw sample through and forget the position
      if (diff > change_threshold) begin
        res.depth = raw;
        row = '0;
      end
    end
    history_rows[pos] = row;
    len = (pixels_per_frame == '0) ? 1 :
          (pixels_per_frame > MAX_PIXELS) ? MAX_PIXELS : pixels_per_frame;
    res.frame_end = (pos + 1 >= len);
    if (res.frame_end) begin
      pixel_pos = 0;
      frame_slot = (frame_slot + 1) % HISTORY_DEPTH;
    end else begin
      pixel_pos = pos + 1;
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_result_t want;
    if (!rst_ni) begin
      history_rows.delete();
      expected_pixels.delete();
      pixels_per_frame = PPF_RESET;
      change_threshold = THR_RESET;
      frame_slot = 0;
      pixel_pos = 0;
      mismatch_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_PIXELS_PER_FRAME) begin
          pixels_per_frame = cfg_data_i[PPF_W-1:0];
        end else if (cfg_idx_i == CFG_CHANGE_THRESHOLD) begin
          change_threshold = cfg_data_i[THR_W-1:0];
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_pixels.push_back(smooth_pixel(depth_sample_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_pixels.size() == 0) begin
          $error("unexpected item: filtered_depth %0d frame_end %0b",
                 filtered_depth_i, frame_end_i);
          mismatch_count_o++;
        end else begin
          want = expected_pixels.pop_front();
          if (filtered_depth_i !== want.depth) begin
            $error("filtered_depth: expected %0d, got %0d", want.depth, filtered_depth_i);
            mismatch_count_o++;
          end
          if (frame_end_i !== want.frame_end) begin
            $error("frame_end: expected %0b, got %0b", want.frame_end, frame_end_i);
            mismatch_count_o++;
          end
        end
      end
    end
    pending_o = expected_pixels.size();
  end

endmodule

[tb/sv/tb.sv]
// Testbench top for the depth temporal average unit: clock, reset, register
// writes, depth stimulus and receiver stalls, plus the final verdict.
// Depends on dta_pkg, depth_temporal_average_unit and depth_average_checker.
module tb;
  import dta_pkg::*;

  // Indexes past the register list; writes there must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_IDX_W'(3);

  localparam int unsigned SCENE_SIZE       = 64;
  localparam int unsigned SETTLE_CYCLES    = 40;
  localparam int unsigned RANDOM_PHASES    = 8;
  localparam int unsigned PIXELS_PER_PHASE = 235;
  localparam int unsigned HOLD_CYCLES      = 400;

  logic                  clk_i;
  logic                  rst_ni         = 1'b0;
  logic                  cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i      = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i     = '0;
  logic                  in_valid_i     = 1'b0;
  logic                  in_stall_o;
  logic [DEPTH_W-1:0]    depth_sample_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i    = 1'b0;
  logic [DEPTH_W-1:0]    filtered_depth_o;
  logic                  frame_end_o;

  int unsigned mismatch_count;
  int unsigned pending_pixels;

  // Traffic shaping, changed only at a falling edge while the input is quiet.
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_req  = 0;
  int unsigned hold_left = 0;

  // Per-position scene depth; random items hover around it so history builds up.
  logic [DEPTH_W-1:0] scene [SCENE_SIZE];
  int unsigned        scene_pos = 0;
  int unsigned        scene_len = 1;

  depth_temporal_average_unit uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .depth_sample_i   (depth_sample_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .filtered_depth_o (filtered_depth_o),
    .frame_end_o      (frame_end_o)
  );

  depth_average_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .depth_sample_i   (depth_sample_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .filtered_depth_i (filtered_depth_o),
    .frame_end_i      (frame_end_o),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending_pixels)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Covers the clearing pass after reset and many times the
  // slowest item stream with every stall and gap at its worst.
  initial begin
    #30_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Receiver: random stalls per cycle, or a long hold-off when one is requested.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Offer one item; insert random idle cycles first, then hold it until taken.
  // Valid is only dropped in a gap, so back-to-back items keep it high.
  task automatic send_pixel(input logic [DEPTH_W-1:0] depth);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    depth_sample_i <= depth;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Stop offering items, wait for every expected result, then let the block settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_pixels != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_traffic(input int unsigned idle, input int unsigned stall,
                             input int unsigned hold);
    @(negedge clk_i);
    idle_pct = idle;
    stall_pct = stall;
    hold_req = hold;
    @(posedge clk_i);
  endtask

  // Mostly small noise around the scene depth, with dropouts, jumps and outliers.
  function automatic logic [DEPTH_W-1:0] next_depth(input int unsigned thr);
    int unsigned r;
    int unsigned spread;
    int unsigned idx;
    int          v;
    logic [DEPTH_W-1:0] depth;
    r = $urandom_range(99);
    spread = (thr > 60) ? 60 : thr + 2;
    idx = scene_pos % SCENE_SIZE;
    if (r < 6) begin
      depth = '0;
    end else if (r < 10) begin
      depth = DEPTH_W'($urandom_range(65535));
    end else begin
      if (r < 16) scene[idx] = DEPTH_W'($urandom_range(65535));
      v = int'(scene[idx]) + int'($urandom_range(2 * spread)) - int'(spread);
      depth = (v < 0) ? '0 : (v > 65535) ? '1 : DEPTH_W'(v);
    end
    scene_pos = (scene_pos + 1 >= scene_len) ? 0 : scene_pos + 1;
    return depth;
  endfunction

  initial begin
    int unsigned frame_len;
    int unsigned thr;
    for (int i = 0; i < SCENE_SIZE; i++) scene[i] = DEPTH_W'($urandom_range(65535));
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: a frame length of zero acts as one, so every item hits
    // position 0 and the slot rotates through the whole history.
    cfg_write(CFG_PIXELS_PER_FRAME, '0);
    cfg_write(CFG_CHANGE_THRESHOLD, CFG_DATA_W'(10));
    send_pixel(16'hFFFF);
    send_pixel(16'hFFFF);
    send_pixel(16'd65530);
    // zero sample against a high average: large change, output 0, history cleared
    send_pixel(16'd0);
    // nothing left in history
    send_pixel(16'd0);
    send_pixel(16'd100);
    send_pixel(16'd200);
    send_pixel(16'd1);
    send_pixel(16'd2);

    // Zero threshold: any deviation passes the raw sample.
    drain();
    cfg_write(CFG_CHANGE_THRESHOLD, '0);
    send_pixel(16'd7);
    send_pixel(16'd8);

    // Upper data bits must be dropped, leaving the largest threshold.
    drain();
    cfg_write(CFG_CHANGE_THRESHOLD, '1);
    send_pixel(16'hFFFF);
    send_pixel(16'd0);

    // Writes past the register list must leave both registers alone.
    drain();
    cfg_write(CFG_SPARE_A, '1);
    cfg_write(CFG_SPARE_B, '0);
    send_pixel(16'd3);

    // Shrink the frame while mid-frame: the next item closes it at once.
    drain();
    cfg_write(CFG_PIXELS_PER_FRAME, CFG_DATA_W'(3));
    send_pixel(16'd40);
    send_pixel(16'd41);
    send_pixel(16'd42);
    send_pixel(16'd43);
    send_pixel(16'd44);
    drain();
    cfg_write(CFG_PIXELS_PER_FRAME, CFG_DATA_W'(2));
    send_pixel(16'd45);
    send_pixel(16'd46);

    // Frame lengths at and above the store size clamp to it.
    drain();
    cfg_write(CFG_PIXELS_PER_FRAME, '1);
    send_pixel(16'hFFFF);
    send_pixel(16'd1);
    drain();
    cfg_write(CFG_PIXELS_PER_FRAME, CFG_DATA_W'(MAX_PIXELS_DEF));
    send_pixel(16'h8000);

    // Random phases: small frames so every position gathers history, a fresh
    // threshold each time, and the four traffic patterns in turn.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain();
      case (phase)
        0: frame_len = 5;
        1: frame_len = 1;
        2: frame_len = 16;
        3: frame_len = 2;
        4: frame_len = 3;
        5: frame_len = 64;
        6: frame_len = 0;
        default: frame_len = 37;
      endcase
      case ($urandom_range(5))
        0: thr = 0;
        1: thr = 3;
        2: thr = 10;
        3: thr = 200;
        4: thr = 65535;
        default: thr = $urandom_range(65535);
      endcase
      cfg_write(CFG_PIXELS_PER_FRAME, CFG_DATA_W'(frame_len));
      cfg_write(CFG_CHANGE_THRESHOLD, CFG_DATA_W'(thr));
      scene_len = (frame_len == 0) ? 1 : frame_len;
      scene_pos = 0;
      // Phase 4 opens with a long receiver hold-off while items keep coming,
      // so the block backs up and stalls its input.
      case (phase % 4)
        0: set_traffic(0, 0, (phase == 4) ? HOLD_CYCLES : 0);
        1: set_traffic(55, 0, 0);
        2: set_traffic(0, 55, 0);
        default: set_traffic(9, 9, 0);
      endcase
      repeat (PIXELS_PER_PHASE) send_pixel(next_depth(thr));
    end

    drain();
    if (mismatch_count == 0 && pending_pixels == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[depth_temporal_average_unit.f]
rtl/dta_pkg.sv
rtl/dta_ram.sv
rtl/dta_div.sv
rtl/depth_temporal_average_unit.sv
rtl/dta_checker.sv
tb/sv/depth_average_checker.sv
tb/sv/tb.sv
